// ===== hw/rtl/rational_compare_macros.svh =====
// Assertion macros shared by the rational compare checker.
`ifndef RATIONAL_COMPARE_MACROS_SVH
`define RATIONAL_COMPARE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RCMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define RCMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/rcmp_pkg.sv =====
// Shared constants, codes and controller/datapath bundles for the rational compare.
package rcmp_pkg;

	localparam int OPERAND_WIDTH = 32;
	localparam int CNT_W         = $clog2(OPERAND_WIDTH);

	typedef logic [OPERAND_WIDTH-1:0] mag_t;

	typedef enum logic [1:0] {
		ORD_LESS    = 2'd0,
		ORD_EQUAL   = 2'd1,
		ORD_GREATER = 2'd2,
		ORD_INVALID = 2'd3
	} order_code_t;

	typedef struct packed {
		logic        load;
		logic        arrange;
		logic        swap;
		logic        div_r;
		logic        div_l;
		logic        advance;
		logic        set_code;
		order_code_t code;
		logic        out_load;
	} rcmp_cmd_t;

	typedef struct packed {
		logic invalid;
		logic left_neg;
		logic right_neg;
		logic p_gt_q;
		logic r_lt_s;
		logic r_gt_s;
		logic p_zero;
		logic r_zero;
		logic div_done;
		logic qr_lt_ql;
		logic qr_gt_ql;
		logic out_free;
	} rcmp_status_t;

endpackage

// ===== hw/rtl/rcmp_req_if.sv =====
// Request channel carrying the two fractions.
interface rcmp_req_if import rcmp_pkg::*; ();
	logic                            valid;
	logic                            ready;
	logic signed [OPERAND_WIDTH-1:0] num_left;
	logic signed [OPERAND_WIDTH-1:0] den_left;
	logic signed [OPERAND_WIDTH-1:0] num_right;
	logic signed [OPERAND_WIDTH-1:0] den_right;

	modport source (output valid, output num_left, output den_left, output num_right,
		output den_right, input ready);
	modport sink (input valid, input num_left, input den_left, input num_right,
		input den_right, output ready);
endinterface

// ===== hw/rtl/rcmp_rsp_if.sv =====
// Response channel carrying the order code.
interface rcmp_rsp_if import rcmp_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] order_code;

	modport source (output valid, output order_code, input ready);
	modport sink (input valid, input order_code, output ready);
endinterface

// ===== hw/rtl/rational_compare.sv =====
// Top level of the rational compare: orders two signed fractions.
// The order is settled by the sign checks, else by the range checks, else by continued-fraction
// rounds, each with two divisions on the one shared divider plus loop control.
// Throughput: one request at a time; the next is taken once the result enters the output register.
// Reset: arst_n clears the controller and the output valid flag; no request is pending after reset.
module rational_compare import rcmp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	rcmp_req_if.sink   req,
	rcmp_rsp_if.source rsp
);

	rcmp_cmd_t    cmd;
	rcmp_status_t sts;

	rcmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rcmp_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_left  (req.num_left),
		.den_left  (req.den_left),
		.num_right (req.num_right),
		.den_right (req.den_right),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_code  (rsp.order_code)
	);

endmodule

// ===== hw/rtl/rcmp_div.sv =====
// Restoring divider, one quotient bit per cycle.
module rcmp_div import rcmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  mag_t dividend,
	input  mag_t divisor,
	output logic done,
	output mag_t quotient,
	output mag_t remainder
);

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	mag_t                   acc_q;
	mag_t                   rem_q;
	mag_t                   dvs_q;
	logic [OPERAND_WIDTH:0] trial;
	logic [OPERAND_WIDTH:0] diff;
	logic                   ge;

	assign trial = {rem_q, acc_q[OPERAND_WIDTH-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = !diff[OPERAND_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(OPERAND_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[OPERAND_WIDTH-2:0], ge};
			rem_q <= ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = acc_q;
	assign remainder = rem_q;

endmodule

// ===== hw/rtl/rcmp_dp.sv =====
// Datapath: operand magnitudes, continued-fraction registers, divider and result register.
module rcmp_dp import rcmp_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic signed [OPERAND_WIDTH-1:0] num_left,
	input  logic signed [OPERAND_WIDTH-1:0] den_left,
	input  logic signed [OPERAND_WIDTH-1:0] num_right,
	input  logic signed [OPERAND_WIDTH-1:0] den_right,
	input  rcmp_cmd_t                       cmd,
	output rcmp_status_t                    sts,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      out_code
);

	function automatic mag_t mag_of(input logic [OPERAND_WIDTH-1:0] v);
		mag_t m;
		m = v[OPERAND_WIDTH-1] ? (~v + OPERAND_WIDTH'(1)) : v;
		return m;
	endfunction

	mag_t        p_q, q_q, r_q, s_q;
	logic        na_q, nb_q, nc_q, nd_q;
	mag_t        qr_q;
	mag_t        rem_r_q;
	order_code_t code_q;
	order_code_t out_code_q;
	logic        out_valid_q;

	logic        left_neg;
	logic        right_neg;
	logic        div_start;
	mag_t        div_dividend;
	mag_t        div_divisor;
	logic        div_done;
	mag_t        div_quo;
	mag_t        div_rem;

	assign left_neg  = (p_q != '0) && (na_q != nb_q);
	assign right_neg = (r_q != '0) && (nc_q != nd_q);

	assign div_start    = cmd.div_r || cmd.div_l;
	assign div_dividend = cmd.div_r ? s_q : q_q;
	assign div_divisor  = cmd.div_r ? r_q : p_q;

	rcmp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			p_q  <= mag_of(num_left);
			q_q  <= mag_of(den_left);
			r_q  <= mag_of(num_right);
			s_q  <= mag_of(den_right);
			na_q <= num_left[OPERAND_WIDTH-1];
			nb_q <= den_left[OPERAND_WIDTH-1];
			nc_q <= num_right[OPERAND_WIDTH-1];
			nd_q <= den_right[OPERAND_WIDTH-1];
		end else if (cmd.arrange && left_neg) begin
			p_q <= r_q;
			q_q <= s_q;
			r_q <= p_q;
			s_q <= q_q;
		end else if (cmd.swap) begin
			p_q <= s_q;
			q_q <= r_q;
			r_q <= q_q;
			s_q <= p_q;
		end else if (cmd.advance) begin
			p_q <= rem_r_q;
			q_q <= r_q;
			r_q <= div_rem;
			s_q <= p_q;
		end
		if (cmd.div_l) begin
			qr_q    <= div_quo;
			rem_r_q <= div_rem;
		end
		if (cmd.set_code) begin
			code_q <= cmd.code;
		end
		if (cmd.out_load) begin
			out_code_q <= code_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.invalid   = (q_q == '0) || (s_q == '0);
		sts.left_neg  = left_neg;
		sts.right_neg = right_neg;
		sts.p_gt_q    = p_q > q_q;
		sts.r_lt_s    = r_q < s_q;
		sts.r_gt_s    = r_q > s_q;
		sts.p_zero    = p_q == '0;
		sts.r_zero    = r_q == '0;
		sts.div_done  = div_done;
		sts.qr_lt_ql  = qr_q < div_quo;
		sts.qr_gt_ql  = qr_q > div_quo;
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid = out_valid_q;
	assign out_code  = out_code_q;

endmodule

// ===== hw/rtl/rcmp_ctrl.sv =====
// Controller: sequences sign checks, ordering and continued-fraction rounds.
module rcmp_ctrl import rcmp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  rcmp_status_t sts,
	output rcmp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_SIGN  = 9'b000000010,
		ST_ORDER = 9'b000000100,
		ST_CHECK = 9'b000001000,
		ST_LOOP  = 9'b000010000,
		ST_DIV_R = 9'b000100000,
		ST_DIV_L = 9'b001000000,
		ST_STEP  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (sts.invalid) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_INVALID;
					state_d      = ST_DONE;
				end else if (sts.left_neg && !sts.right_neg) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_LESS;
					state_d      = ST_DONE;
				end else if (!sts.left_neg && sts.right_neg) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_GREATER;
					state_d      = ST_DONE;
				end else begin
					cmd.arrange = 1'b1;
					state_d     = ST_ORDER;
				end
			end
			ST_ORDER: begin
				if (sts.p_gt_q && sts.r_lt_s) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_GREATER;
					state_d      = ST_DONE;
				end else begin
					cmd.swap = sts.p_gt_q;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.r_gt_s) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_LESS;
					state_d      = ST_DONE;
				end else begin
					state_d = ST_LOOP;
				end
			end
			ST_LOOP: begin
				if (sts.p_zero) begin
					cmd.set_code = 1'b1;
					cmd.code     = sts.r_zero ? ORD_EQUAL : ORD_LESS;
					state_d      = ST_DONE;
				end else if (sts.r_zero) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_GREATER;
					state_d      = ST_DONE;
				end else begin
					cmd.div_r = 1'b1;
					state_d   = ST_DIV_R;
				end
			end
			ST_DIV_R: begin
				if (sts.div_done) begin
					cmd.div_l = 1'b1;
					state_d   = ST_DIV_L;
				end
			end
			ST_DIV_L: begin
				if (sts.div_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (sts.qr_lt_ql) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_LESS;
					state_d      = ST_DONE;
				end else if (sts.qr_gt_ql) begin
					cmd.set_code = 1'b1;
					cmd.code     = ORD_GREATER;
					state_d      = ST_DONE;
				end else begin
					cmd.advance = 1'b1;
					state_d     = ST_LOOP;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/rcmp_chk.sv =====
// Port-level checker for the rational compare and its bind.
`include "rational_compare_macros.svh"

module rcmp_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] order_code
);

	`RCMP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
	`RCMP_ASSERT_NEXT(a_code_hold, rsp_valid && !rsp_ready, $stable(order_code), "code changed")
	`RCMP_ASSERT_NEXT(a_one_at_time, req_valid && req_ready, !req_ready, "second request taken")
	`RCMP_ASSERT_NOW(a_rsp_after_busy, $rose(rsp_valid), !$past(req_ready), "response while idle")

endmodule

bind rational_compare rcmp_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.order_code (rsp.order_code)
);

// ===== tb/rcmp_order_checker.sv =====
// Checker for the rational compare: predicts each order code and compares responses.
`timescale 1ns / 100ps

module rcmp_order_checker import rcmp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	rcmp_req_if  req,
	rcmp_rsp_if  rsp,
	output int   errors,
	output int   pending
);

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

	typedef struct {
		operand_t    num_left;
		operand_t    den_left;
		operand_t    num_right;
		operand_t    den_right;
		order_code_t order;
	} order_req_t;

	order_req_t expected_orders[$];

	function automatic mag_t magnitude(operand_t v);
		return v[OPERAND_WIDTH-1] ? mag_t'(-v) : mag_t'(v);
	endfunction

	// Order p/q against r/s with p, r >= 0 and q, s > 0.
	function automatic order_code_t order_positive(mag_t p, mag_t q, mag_t r, mag_t s);
		mag_t qr;
		mag_t ql;
		mag_t op;
		mag_t oq;
		if (p > q) begin
			if (r < s)
				return ORD_GREATER;
			op = p;
			oq = q;
			p = s;
			q = r;
			r = oq;
			s = op;
		end
		if (r > s)
			return ORD_LESS;
		while (p != 0 && r != 0) begin
			qr = s / r;
			ql = q / p;
			op = p;
			oq = q;
			if (qr < ql)
				return ORD_LESS;
			if (qr > ql)
				return ORD_GREATER;
			p = s % r;
			q = r;
			r = oq % op;
			s = op;
		end
		if (p == 0)
			return (r == 0) ? ORD_EQUAL : ORD_LESS;
		return ORD_GREATER;
	endfunction

	function automatic order_code_t predict_order(operand_t nl, operand_t dl, operand_t nr,
		operand_t dr);
		mag_t a;
		mag_t b;
		mag_t c;
		mag_t d;
		logic left_neg;
		logic right_neg;
		a = magnitude(nl);
		b = magnitude(dl);
		c = magnitude(nr);
		d = magnitude(dr);
		if (b == 0 || d == 0)
			return ORD_INVALID;
		left_neg  = (a != 0) && (nl[OPERAND_WIDTH-1] != dl[OPERAND_WIDTH-1]);
		right_neg = (c != 0) && (nr[OPERAND_WIDTH-1] != dr[OPERAND_WIDTH-1]);
		if (left_neg && !right_neg)
			return ORD_LESS;
		if (!left_neg && right_neg)
			return ORD_GREATER;
		if (left_neg)
			return order_positive(c, d, a, b);
		return order_positive(a, b, c, d);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		order_req_t head;
		order_req_t item;
		if (!arst_n) begin
			expected_orders.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_orders.size() == 0) begin
					$display("%0t: response with no request pending, expected none got %0d",
						$time, rsp.order_code);
					errors <= errors + 1;
				end else begin
					head = expected_orders.pop_front();
					if (rsp.order_code !== head.order) begin
						$display("%0t: order_code mismatch for %0d/%0d vs %0d/%0d, expected %0d got %0d",
							$time, head.num_left, head.den_left, head.num_right,
							head.den_right, head.order, rsp.order_code);
						errors <= errors + 1;
					end
				end
			end
			if (req.valid && req.ready) begin
				item.num_left  = req.num_left;
				item.den_left  = req.den_left;
				item.num_right = req.num_right;
				item.den_right = req.den_right;
				item.order     = predict_order(req.num_left, req.den_left, req.num_right,
					req.den_right);
				expected_orders.push_back(item);
			end
			pending <= expected_orders.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the rational compare: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 100ps

module tb;
	import rcmp_pkg::*;

	typedef logic signed [OPERAND_WIDTH-1:0] operand_t;

	localparam int       RANDOM_ITEMS = 1925;
	localparam int       IDLE_LIMIT   = 20000;
	localparam operand_t OP_MIN       = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};
	localparam operand_t OP_MAX       = {1'b0, {(OPERAND_WIDTH-1){1'b1}}};

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_orders;
	int   burst_left;
	int   idle_cycles;
	int   ready_mode;
	int   ready_phase;

	rcmp_req_if req();
	rcmp_rsp_if rsp();

	rational_compare dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	rcmp_order_checker order_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.errors  (fail_count),
		.pending (pending_orders)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (ready_phase == 0) begin
			ready_mode  <= $urandom_range(0, 3);
			ready_phase <= $urandom_range(50, 600);
		end else begin
			ready_phase <= ready_phase - 1;
		end
		case (ready_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 1) == 0);
			2: rsp.ready <= ($urandom_range(0, 7) == 0);
			default: rsp.ready <= ($urandom_range(0, 15) != 0);
		endcase
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic issue(input operand_t nl, input operand_t dl, input operand_t nr,
		input operand_t dr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req.valid     <= 1'b1;
		req.num_left  <= nl;
		req.den_left  <= dl;
		req.num_right <= nr;
		req.den_right <= dr;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic hold_until_drained();
		req.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_orders != 0) @(posedge clk);
	endtask

	// Negate numerator and denominator together: value kept, signs vary.
	task automatic flip_pair(inout operand_t n, inout operand_t d);
		if ($urandom_range(0, 1)) begin
			n = -n;
			d = -d;
		end
	endtask

	function automatic operand_t boundary_value();
		case ($urandom_range(0, 6))
			0: return OP_MIN;
			1: return OP_MAX;
			2: return -OP_MAX;
			3: return 0;
			4: return 1;
			5: return -1;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		longint   fib[0:46];
		int       p;
		int       q;
		int       k1;
		int       k2;
		int       e;
		int       n;
		int       kind;
		operand_t nl;
		operand_t dl;
		operand_t nr;
		operand_t dr;

		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.num_left  <= '0;
		req.den_left  <= '0;
		req.num_right <= '0;
		req.den_right <= '0;
		burst_left = 0;
		fib[0] = 0;
		fib[1] = 1;
		for (int i = 2; i <= 46; i++)
			fib[i] = fib[i-1] + fib[i-2];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(1, 2, 1, 3);
		issue(1, 3, 1, 2);
		issue(2, 4, 1, 2);
		issue(0, 5, 0, -7);
		issue(0, 1, -1, 3);
		issue(-1, 3, 1, 3);
		issue(3, 0, 1, 1);
		issue(1, 1, 1, 0);
		issue(0, 0, 0, 0);
		issue(OP_MIN, 1, OP_MAX, 1);
		issue(OP_MIN, OP_MIN, 1, 1);
		issue(OP_MAX, OP_MIN, -1, 1);
		issue(OP_MIN, OP_MAX, OP_MIN, OP_MAX);
		issue(OP_MAX, 1, OP_MAX, 1);
		issue(1, OP_MAX, 1, OP_MIN);
		issue(-3, -4, 3, 4);
		issue(-5, 7, -4, 7);
		issue(7, -5, -4, 3);
		issue(1836311903, 1134903170, 1134903170, 701408733);
		issue(5, 3, 2, 1);
		issue(5, 3, 1, 2);
		issue(2, 1, 2, 1);
		issue(-1, -1, OP_MAX, OP_MAX);
		issue(1, OP_MAX, 0, OP_MAX);
		issue(OP_MIN, -1, OP_MAX, 1);
		hold_until_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 19);
			case (kind)
				0, 1, 2, 3: begin
					nl = $urandom;
					dl = $urandom;
					nr = $urandom;
					dr = $urandom;
				end
				4, 5: begin
					nl = int'($urandom_range(0, 40)) - 20;
					dl = int'($urandom_range(0, 40)) - 20;
					nr = int'($urandom_range(0, 40)) - 20;
					dr = int'($urandom_range(0, 40)) - 20;
				end
				6, 7, 8: begin
					p  = $urandom_range(0, 65535);
					q  = $urandom_range(1, 65535);
					k1 = $urandom_range(1, 32767);
					k2 = $urandom_range(1, 32767);
					nl = p * k1;
					dl = q * k1;
					nr = p * k2;
					dr = q * k2;
					flip_pair(nl, dl);
					flip_pair(nr, dr);
				end
				9: begin
					n  = $urandom_range(2, 44);
					nl = operand_t'(fib[n+1]);
					dl = operand_t'(fib[n]);
					if ($urandom_range(0, 1)) begin
						nr = operand_t'(fib[n]);
						dr = operand_t'(fib[n-1]);
					end else begin
						nr = operand_t'(fib[n+2]);
						dr = operand_t'(fib[n+1]);
					end
					if ($urandom_range(0, 1)) begin
						nl = -nl;
						nr = -nr;
					end
					flip_pair(nl, dl);
					flip_pair(nr, dr);
				end
				10, 11, 12: begin
					p  = $urandom_range(0, 65535);
					q  = $urandom_range(1, 65535);
					k1 = $urandom_range(1, 32767);
					e  = int'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1)) begin
						nl = p;
						dl = q;
						nr = p * k1 + e;
						dr = q * k1;
					end else begin
						nl = p * k1 + e;
						dl = q * k1;
						nr = p;
						dr = q;
					end
					flip_pair(nl, dl);
					flip_pair(nr, dr);
				end
				13, 14: begin
					nl = boundary_value();
					dl = boundary_value();
					nr = boundary_value();
					dr = boundary_value();
				end
				default: begin
					nl = $urandom >> 1;
					dl = $urandom >> 1;
					nr = $urandom >> 1;
					dr = $urandom >> 1;
					flip_pair(nl, dl);
					flip_pair(nr, dr);
				end
			endcase
			issue(nl, dl, nr, dr);
			if ($urandom_range(0, 199) == 0)
				hold_until_drained();
		end

		hold_until_drained();
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
